FILE: rtl/tesc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tesc_pkg
// Shared types and constants for the touch event to screen coordinate block.
// ----------------------------------------------------------------------------
package tesc_pkg;

    // Field widths
    localparam int TYPE_W  = 5;
    localparam int CODE_W  = 10;
    localparam int VALUE_W = 32;
    localparam int SIZE_W  = 16;
    localparam int COORD_W = 8;
    localparam int CFG_IDX_W = 4;

    // Event classes and codes (Linux input numbering)
    localparam logic [TYPE_W-1:0]  EVT_SYN        = 5'd0;
    localparam logic [TYPE_W-1:0]  EVT_KEY        = 5'd1;
    localparam logic [TYPE_W-1:0]  EVT_ABS        = 5'd3;
    localparam logic [CODE_W-1:0]  CODE_TOUCH_KEY = 10'h14a;
    localparam logic [CODE_W-1:0]  CODE_POS_X     = 10'h035;
    localparam logic [CODE_W-1:0]  CODE_POS_Y     = 10'h036;
    localparam logic [CODE_W-1:0]  CODE_TRACK_ID  = 10'h039;
    localparam logic [CODE_W-1:0]  CODE_REPORT    = 10'h000;
    localparam logic [VALUE_W-1:0] TRACK_RELEASE  = 32'hffff_ffff;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PANEL_WIDTH  = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PANEL_HEIGHT = 4'd1;

    // Screen limits
    localparam logic [COORD_W-1:0] SCREEN_X_MAX = 8'd255;
    localparam logic [COORD_W-1:0] SCREEN_Y_MAX = 8'd191;

    // Divider: dividend = coord * span < 2^24, quotient <= 256 fits 9 bits
    localparam int NUM_W     = 24;
    localparam int DIV_STEPS = 9;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    typedef struct packed {
        logic [TYPE_W-1:0]         event_type;
        logic [CODE_W-1:0]         event_code;
        logic signed [VALUE_W-1:0] event_value;
    } t_event;

    typedef struct packed {
        logic [COORD_W-1:0] screen_x;
        logic [COORD_W-1:0] screen_y;
        logic               touch_down;
    } t_result;

    typedef struct packed {
        logic [CFG_IDX_W-1:0] cfg_index;
        logic [SIZE_W-1:0]    cfg_data;
    } t_cfg_wr;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV_X,
        S_LOAD_Y,
        S_DIV_Y,
        S_STORE_Y,
        S_OUT
    } t_state;

    typedef struct packed {
        logic ev_apply;   // update held / pending state from the input event
        logic div_load;   // load divider from clamped, scaled coordinate
        logic sel_y;      // divider operand select on load
        logic div_step;   // one restoring division step
        logic store_x;    // write saturated quotient to scaled X
        logic store_y;    // write saturated quotient to scaled Y, clear pending
        logic out_load;   // capture result into output register
    } t_dp_cmd;

    typedef struct packed {
        logic conv_req;       // input event is a report that triggers conversion
        logic pending_valid;
    } t_dp_status;

endpackage

FILE: rtl/tesc_stream_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tesc_stream_if
// Valid/ready channel carrying one payload of parameter type T.
// ----------------------------------------------------------------------------
interface tesc_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/tesc_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tesc_ctrl
// Sequencer: event acceptance, two divider passes, result handoff.
// ----------------------------------------------------------------------------
module tesc_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic                  i_out_ready,
    output logic                  o_out_valid,
    input  tesc_pkg::t_dp_status  i_status,
    output tesc_pkg::t_dp_cmd     o_cmd
);
    import tesc_pkg::*;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_out_valid, n_out_valid;
    logic             accept;
    logic             last_step;

    assign accept    = i_in_valid && (r_state == S_IDLE);
    assign last_step = (r_cnt == CNT_W'(DIV_STEPS - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid && !i_out_ready;
        o_in_ready  = 1'b0;
        o_cmd       = '0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (accept) begin
                    o_cmd.ev_apply = 1'b1;
                    if (i_status.conv_req) begin
                        o_cmd.div_load = 1'b1;
                        n_cnt          = '0;
                        n_state        = S_DIV_X;
                    end else begin
                        n_state = S_OUT;
                    end
                end
            end
            S_DIV_X: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt + 1'b1;
                if (last_step) n_state = S_LOAD_Y;
            end
            S_LOAD_Y: begin
                o_cmd.store_x  = 1'b1;
                o_cmd.div_load = 1'b1;
                o_cmd.sel_y    = 1'b1;
                n_cnt          = '0;
                n_state        = S_DIV_Y;
            end
            S_DIV_Y: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt + 1'b1;
                if (last_step) n_state = S_STORE_Y;
            end
            S_STORE_Y: begin
                o_cmd.store_y = 1'b1;
                n_state       = S_OUT;
            end
            S_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_out_valid = r_out_valid;

endmodule

FILE: rtl/tesc_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tesc_datapath
// Event state, panel size registers, clamp/scale, shared restoring divider.
// ----------------------------------------------------------------------------
module tesc_datapath (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  tesc_pkg::t_event      i_event,
    input  logic                  i_cfg_we,
    input  tesc_pkg::t_cfg_wr     i_cfg,
    input  tesc_pkg::t_dp_cmd     i_cmd,
    output tesc_pkg::t_dp_status  o_status,
    output tesc_pkg::t_result     o_result
);
    import tesc_pkg::*;

    localparam int Q_W = DIV_STEPS;

    logic [SIZE_W-1:0]         r_width, r_height;
    logic                      r_held;
    logic signed [VALUE_W-1:0] r_pend_x, r_pend_y;
    logic                      r_pend_valid;
    logic [COORD_W-1:0]        r_scaled_x, r_scaled_y;

    logic [SIZE_W-1:0]         r_rem, r_den;
    logic [Q_W-1:0]            r_low, r_quo;
    t_result                   r_out;

    logic [SIZE_W-1:0] clamp_x, clamp_y;
    logic [NUM_W-1:0]  num_x, num_y, num_sel;
    logic [SIZE_W:0]   trial;
    logic              ge;
    logic [COORD_W-1:0] sat_x, sat_y;

    // Clamp a signed coordinate to 0..limit
    function automatic logic [SIZE_W-1:0] clamp_coord(
        input logic signed [VALUE_W-1:0] raw,
        input logic [SIZE_W-1:0]         limit
    );
        logic [SIZE_W-1:0] res;
        if (raw[VALUE_W-1])
            res = '0;
        else if (raw > $signed({{(VALUE_W-SIZE_W){1'b0}}, limit}))
            res = limit;
        else
            res = raw[SIZE_W-1:0];
        return res;
    endfunction

    assign clamp_x = clamp_coord(r_pend_x, r_width);
    assign clamp_y = clamp_coord(r_pend_y, r_height);
    // x * 256, y * 192 = y*128 + y*64
    assign num_x   = {clamp_x, 8'b0};
    assign num_y   = {1'b0, clamp_y, 7'b0} + {2'b0, clamp_y, 6'b0};
    assign num_sel = i_cmd.sel_y ? num_y : num_x;

    assign trial = {r_rem, r_low[Q_W-1]};
    assign ge    = (trial >= {1'b0, r_den});

    assign sat_x = r_quo[Q_W-1] ? SCREEN_X_MAX : r_quo[COORD_W-1:0];
    assign sat_y = (r_quo > {1'b0, SCREEN_Y_MAX}) ? SCREEN_Y_MAX : r_quo[COORD_W-1:0];

    assign o_status.conv_req = (i_event.event_type == EVT_SYN) &&
                               (i_event.event_code == CODE_REPORT) &&
                               r_pend_valid && (r_width != '0) && (r_height != '0);
    assign o_status.pending_valid = r_pend_valid;

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width      <= '0;
            r_height     <= '0;
            r_held       <= 1'b0;
            r_pend_x     <= '0;
            r_pend_y     <= '0;
            r_pend_valid <= 1'b0;
            r_scaled_x   <= '0;
            r_scaled_y   <= '0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg.cfg_index == REG_PANEL_WIDTH)  r_width  <= i_cfg.cfg_data;
                if (i_cfg.cfg_index == REG_PANEL_HEIGHT) r_height <= i_cfg.cfg_data;
            end
            if (i_cmd.ev_apply) begin
                if (i_event.event_type == EVT_KEY &&
                    i_event.event_code == CODE_TOUCH_KEY) begin
                    r_held <= (i_event.event_value != '0);
                end else if (i_event.event_type == EVT_ABS) begin
                    if (i_event.event_code == CODE_POS_X) begin
                        r_pend_x     <= i_event.event_value;
                        r_pend_valid <= 1'b1;
                    end else if (i_event.event_code == CODE_POS_Y) begin
                        r_pend_y     <= i_event.event_value;
                        r_pend_valid <= 1'b1;
                    end else if (i_event.event_code == CODE_TRACK_ID &&
                                 i_event.event_value == TRACK_RELEASE) begin
                        r_held <= 1'b0;
                    end
                end
            end
            if (i_cmd.store_x) r_scaled_x <= sat_x;
            if (i_cmd.store_y) begin
                r_scaled_y   <= sat_y;
                r_pend_valid <= 1'b0;
            end
        end
    end

    // Divider and output payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.div_load) begin
            // quotient < 2^9, so the top bits already sit below the divisor
            r_rem <= {{(SIZE_W-NUM_W+Q_W){1'b0}}, num_sel[NUM_W-1:Q_W]};
            r_low <= num_sel[Q_W-1:0];
            r_quo <= '0;
            r_den <= i_cmd.sel_y ? r_height : r_width;
        end else if (i_cmd.div_step) begin
            r_rem <= ge ? SIZE_W'(trial - {1'b0, r_den}) : trial[SIZE_W-1:0];
            r_low <= {r_low[Q_W-2:0], 1'b0};
            r_quo <= {r_quo[Q_W-2:0], ge};
        end
        if (i_cmd.out_load) begin
            r_out.screen_x   <= r_scaled_x;
            r_out.screen_y   <= r_scaled_y;
            r_out.touch_down <= r_held;
        end
    end

    assign o_result = r_out;

endmodule

FILE: rtl/touch_event_to_screen_coords.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// touch_event_to_screen_coords
// Converts touch panel input events into 256x192 screen coordinates.
// ----------------------------------------------------------------------------
// Each event transaction on i_event yields exactly one result transaction on
// o_result carrying the current screen X/Y and touch state. Key, axis and
// ignored events go from acceptance through S_OUT to the output register, and
// the next event is taken after that. A report event with a pending position
// and both panel sizes nonzero is converted first: X and Y are each run
// through one shared 9-step restoring divider (one subtract and compare per
// cycle), with the states S_DIV_X, S_LOAD_Y, S_DIV_Y, S_STORE_Y and S_OUT in
// that order. Results sit in an output register, so the next event is
// accepted while the previous result waits to be taken. Panel sizes are
// written through i_cfg (index 0 width, index 1 height); i_cfg is always
// ready and should only be written while the block is idle.
// ----------------------------------------------------------------------------
module touch_event_to_screen_coords (
    input  logic  i_clk,
    input  logic  i_rst_n,
    tesc_stream_if.sink   i_event,
    tesc_stream_if.source o_result,
    tesc_stream_if.sink   i_cfg
);
    import tesc_pkg::*;

    t_dp_cmd    cmd;
    t_dp_status status;

    assign i_cfg.ready = 1'b1;

    tesc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_event.valid),
        .o_in_ready  (i_event.ready),
        .i_out_ready (o_result.ready),
        .o_out_valid (o_result.valid),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    tesc_datapath u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_event  (i_event.data),
        .i_cfg_we (i_cfg.valid),
        .i_cfg    (i_cfg.data),
        .i_cmd    (cmd),
        .o_status (status),
        .o_result (o_result.data)
    );

`ifndef NO_ASSERTIONS
    // A conversion request starts the divider on the next cycle
    a_conv_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_event.valid && i_event.ready && status.conv_req) |=> cmd.div_step)
        else $error("conversion did not start divider");

    // No new event while the divider is busy
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_event.ready |-> !cmd.div_step)
        else $error("event accepted during division");

    // Finishing a conversion clears the pending position
    a_pending_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.store_y |=> !status.pending_valid)
        else $error("pending mark not cleared after conversion");

    // Output Y never exceeds the screen height
    a_y_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid |-> (o_result.data.screen_y <= SCREEN_Y_MAX))
        else $error("screen_y out of range");
`endif

endmodule
